@@ sv/mgpc_pkg.sv @@
// shared types and constants of the masked grid pattern claim unit
// no dependencies
`default_nettype none

package mgpc_pkg;

    // input action codes
    typedef enum logic [2:0] {
        ACT_GRID_CELL = 3'd0,
        ACT_PAT_CELL  = 3'd1,
        ACT_PAT_HEAD  = 3'd2,
        ACT_CLEAR     = 3'd3,
        ACT_PROBE     = 3'd4
    } action_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_ID_MASK     = 2'd2,
        CFG_UNDEF_CODE  = 2'd3
    } cfg_index_t;

    localparam int RESULT_LIMIT = 16;
    localparam int RC_W         = 5;
    localparam int CFG_DATA_W   = 16;

    // control state, one-hot
    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_HEAD   = 9'b000000100,
        S_MISSUE = 9'b000001000,
        S_MCHK   = 9'b000010000,
        S_CISSUE = 9'b000100000,
        S_CDRAIN = 9'b001000000,
        S_NEXT   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

@@ sv/masked_grid_pattern_claim_unit.sv @@
// masked grid pattern claim unit: grid, pattern and claim memories with a
// sequencer that walks pattern cells one per cycle
// depends on mgpc_pkg
`default_nettype none

// How the block is used
// - command channel: a transaction is taken at a rising edge with start high
//   and busy low; action selects grid cell write, pattern cell write, pattern
//   header write, claim clear or probe
// - cell and header writes leave the block idle; busy stays low
// - a probe walks the enabled patterns in index order; for each pattern that
//   fits, its cells are read from the pattern and grid memories until one
//   fails or all are read, one cell a cycle through registered reads; an
//   accepted match walks the pattern once more to mark its member cells
//   in the claim memory
// - result transactions appear on the match ports for one cycle, marked by
//   result_strobe; one match is held back until the next is known so that
//   last can be set on the final one of a probe; the receiver cannot stall
// - a claim clear, and reset, sweep the claim memory one entry a cycle,
//   all MAX_GRID_W * MAX_GRID_H entries, with busy high;
//   configuration writes are taken at any time
// - grid and pattern cells are undefined until written; headers reset to
//   disabled
module masked_grid_pattern_claim_unit #(
    parameter int MAX_GRID_W   = 256,
    parameter int MAX_GRID_H   = 256,
    parameter int MAX_PATTERNS = 16,
    parameter int MAX_PAT_SIDE = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [2:0]                     action,
    input  wire logic [7:0]                     col,
    input  wire logic [7:0]                     row,
    input  wire logic [15:0]                    raw_cell,
    input  wire logic [3:0]                     pattern_index,
    input  wire logic [15:0]                    wanted_id,
    input  wire logic                           member,
    input  wire logic [4:0]                     pat_width,
    input  wire logic [4:0]                     pat_height,
    input  wire logic                           enabled,
    // configuration port
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [mgpc_pkg::CFG_DATA_W-1:0] cfg_data,
    // result channel
    output logic                                result_strobe,
    output logic [3:0]                          match_pattern,
    output logic [7:0]                          match_col,
    output logic [7:0]                          match_row,
    output logic                                accepted,
    output logic                                last
);
    import mgpc_pkg::*;

    localparam int GRID_DEPTH = MAX_GRID_W * MAX_GRID_H;
    localparam int GA_W  = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int PAT_DEPTH = MAX_PATTERNS * MAX_PAT_SIDE * MAX_PAT_SIDE;
    localparam int PA_W  = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
    localparam int PI_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CI_W  = (MAX_PAT_SIDE > 1) ? $clog2(MAX_PAT_SIDE) : 1;
    localparam int PS_W  = $clog2(MAX_PAT_SIDE + 1);
    localparam int GW_W  = $clog2(MAX_GRID_W + 1);
    localparam int GH_W  = $clog2(MAX_GRID_H + 1);

    // configuration registers
    logic [8:0]  grid_width_reg, grid_height_reg;
    logic [15:0] id_mask_reg, undef_code_reg;

    // pattern headers
    logic [PS_W-1:0] hdr_w_reg [MAX_PATTERNS];
    logic [PS_W-1:0] hdr_h_reg [MAX_PATTERNS];
    logic            hdr_on_reg [MAX_PATTERNS];

    // memories
    logic [15:0] grid_mem  [GRID_DEPTH];
    logic [16:0] pat_mem   [PAT_DEPTH];
    logic        claim_mem [GRID_DEPTH];
    logic [15:0] grid_rd_reg;
    logic [16:0] pat_rd_reg;
    logic        claim_rd_reg;

    // sequencer
    state_t          state_reg, state_next;
    logic [GA_W-1:0] clr_reg;
    logic [PI_W-1:0] p_reg;
    logic [CI_W-1:0] c_reg, r_reg;
    logic [7:0]      org_col_reg, org_row_reg;
    logic            s_vld_reg, s_claim_reg;
    logic [GA_W-1:0] s_addr_reg;
    logic            own_reg;
    logic [RC_W-1:0] cnt_reg;
    logic            pend_vld_reg, pend_acc_reg;
    logic [PI_W-1:0] pend_pat_reg;

    logic            accept;
    logic [GW_W-1:0] gw;
    logic [GH_W-1:0] gh;
    logic [PS_W-1:0] cur_w, cur_h;
    logic            fits, last_cell, p_last;
    logic [GA_W-1:0] issue_ga, wr_ga;
    logic [PA_W-1:0] issue_pa, wr_pa;
    logic            cell_member, cell_bad, cell_own;
    logic            grid_we, pat_we, claim_we;
    logic [GA_W-1:0] claim_waddr;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // grid size in use, clamped
    always_comb
    begin
        if (grid_width_reg == 9'd0)
            gw = GW_W'(1);
        else if (32'(grid_width_reg) > MAX_GRID_W)
            gw = GW_W'(MAX_GRID_W);
        else
            gw = GW_W'(grid_width_reg);
        if (grid_height_reg == 9'd0)
            gh = GH_W'(1);
        else if (32'(grid_height_reg) > MAX_GRID_H)
            gh = GH_W'(MAX_GRID_H);
        else
            gh = GH_W'(grid_height_reg);
    end

    assign cur_w     = hdr_w_reg[p_reg];
    assign cur_h     = hdr_h_reg[p_reg];
    assign fits      = (32'(org_col_reg) + 32'(cur_w) <= 32'(gw)) &&
                       (32'(org_row_reg) + 32'(cur_h) <= 32'(gh));
    assign last_cell = (PS_W'(c_reg) == cur_w - PS_W'(1)) &&
                       (PS_W'(r_reg) == cur_h - PS_W'(1));
    assign p_last    = (p_reg == PI_W'(MAX_PATTERNS - 1));

    // addresses
    assign issue_ga = GA_W'((32'(org_row_reg) + 32'(r_reg)) * MAX_GRID_W
                            + 32'(org_col_reg) + 32'(c_reg));
    assign issue_pa = PA_W'((32'(p_reg) * MAX_PAT_SIDE + 32'(r_reg)) * MAX_PAT_SIDE
                            + 32'(c_reg));
    assign wr_ga    = GA_W'(32'(row) * MAX_GRID_W + 32'(col));
    assign wr_pa    = PA_W'((32'(pattern_index) * MAX_PAT_SIDE + 32'(row)) * MAX_PAT_SIDE
                            + 32'(col));

    // check of the cell that came back from the memories
    assign cell_member = s_vld_reg && pat_rd_reg[16];
    assign cell_bad    = cell_member && ((grid_rd_reg == undef_code_reg) ||
                         ((grid_rd_reg & id_mask_reg) != pat_rd_reg[15:0]));
    assign cell_own    = cell_member && claim_rd_reg;

    assign grid_we  = accept && (action == ACT_GRID_CELL) &&
                      (32'(col) < MAX_GRID_W) && (32'(row) < MAX_GRID_H);
    assign pat_we   = accept && (action == ACT_PAT_CELL) &&
                      (32'(pattern_index) < MAX_PATTERNS) &&
                      (32'(col) < MAX_PAT_SIDE) && (32'(row) < MAX_PAT_SIDE);
    assign claim_we = (state_reg == S_CLEAR) ||
                      (s_vld_reg && s_claim_reg && pat_rd_reg[16]);
    assign claim_waddr = (state_reg == S_CLEAR) ? clr_reg : s_addr_reg;

    // memories, registered read
    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[wr_ga] <= raw_cell;
        grid_rd_reg <= grid_mem[issue_ga];
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
            pat_mem[wr_pa] <= {member, wanted_id};
        pat_rd_reg <= pat_mem[issue_pa];
    end

    always_ff @(posedge clk)
    begin
        if (claim_we)
            claim_mem[claim_waddr] <= (state_reg != S_CLEAR);
        claim_rd_reg <= claim_mem[issue_ga];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_reg == GA_W'(GRID_DEPTH - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (accept && action == ACT_CLEAR)
                    state_next = S_CLEAR;
                else if (accept && action == ACT_PROBE)
                    state_next = S_HEAD;
            S_HEAD:
                state_next = (hdr_on_reg[p_reg] && fits) ? S_MISSUE : S_NEXT;
            S_MISSUE:
                if (cell_bad)
                    state_next = S_NEXT;
                else if (last_cell)
                    state_next = S_MCHK;
            S_MCHK:
                if (cell_bad)
                    state_next = S_NEXT;
                else if (!(own_reg || cell_own))
                    state_next = S_CISSUE;
                else
                    state_next = S_NEXT;
            S_CISSUE:
                if (last_cell)
                    state_next = S_CDRAIN;
            S_CDRAIN:
                state_next = S_NEXT;
            S_NEXT:
                state_next = (p_last || cnt_reg == RC_W'(RESULT_LIMIT)) ? S_DONE : S_HEAD;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
            id_mask_reg     <= 16'd1023;
            undef_code_reg  <= 16'hFFFF;
            for (int i = 0; i < MAX_PATTERNS; i++)
            begin
                hdr_w_reg[i]  <= PS_W'(1);
                hdr_h_reg[i]  <= PS_W'(1);
                hdr_on_reg[i] <= 1'b0;
            end
            p_reg         <= '0;
            c_reg         <= '0;
            r_reg         <= '0;
            s_vld_reg     <= 1'b0;
            s_claim_reg   <= 1'b0;
            own_reg       <= 1'b0;
            cnt_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            result_strobe <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            result_strobe <= 1'b0;
            s_vld_reg     <= (state_reg == S_MISSUE) || (state_reg == S_CISSUE);
            s_claim_reg   <= (state_reg == S_CISSUE);

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[8:0];
                    CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[8:0];
                    CFG_ID_MASK:     id_mask_reg     <= cfg_data;
                    CFG_UNDEF_CODE:  undef_code_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // header write, sides clamped into 1..MAX_PAT_SIDE
            if (accept && action == ACT_PAT_HEAD && 32'(pattern_index) < MAX_PATTERNS)
            begin
                if (pat_width == 5'd0)
                    hdr_w_reg[PI_W'(pattern_index)] <= PS_W'(1);
                else if (32'(pat_width) > MAX_PAT_SIDE)
                    hdr_w_reg[PI_W'(pattern_index)] <= PS_W'(MAX_PAT_SIDE);
                else
                    hdr_w_reg[PI_W'(pattern_index)] <= PS_W'(pat_width);
                if (pat_height == 5'd0)
                    hdr_h_reg[PI_W'(pattern_index)] <= PS_W'(1);
                else if (32'(pat_height) > MAX_PAT_SIDE)
                    hdr_h_reg[PI_W'(pattern_index)] <= PS_W'(MAX_PAT_SIDE);
                else
                    hdr_h_reg[PI_W'(pattern_index)] <= PS_W'(pat_height);
                hdr_on_reg[PI_W'(pattern_index)] <= enabled;
            end

            unique case (state_reg)
                S_CLEAR:
                    clr_reg <= clr_reg + GA_W'(1);
                S_IDLE:
                begin
                    clr_reg      <= '0;
                    p_reg        <= '0;
                    cnt_reg      <= '0;
                    pend_vld_reg <= 1'b0;
                    if (accept)
                    begin
                        org_col_reg <= col;
                        org_row_reg <= row;
                    end
                end
                S_HEAD:
                begin
                    c_reg   <= '0;
                    r_reg   <= '0;
                    own_reg <= 1'b0;
                end
                S_MISSUE, S_CISSUE:
                begin
                    s_addr_reg <= issue_ga;
                    own_reg    <= own_reg || cell_own;
                    // walk columns, then rows
                    if (PS_W'(c_reg) == cur_w - PS_W'(1))
                    begin
                        c_reg <= '0;
                        r_reg <= r_reg + CI_W'(1);
                    end
                    else
                        c_reg <= c_reg + CI_W'(1);
                end
                S_MCHK:
                begin
                    c_reg <= '0;
                    r_reg <= '0;
                    if (!cell_bad)
                    begin
                        // release the held match, hold this one back
                        if (pend_vld_reg)
                        begin
                            result_strobe <= 1'b1;
                            match_pattern <= 4'(pend_pat_reg);
                            match_col     <= org_col_reg;
                            match_row     <= org_row_reg;
                            accepted      <= pend_acc_reg;
                            last          <= 1'b0;
                        end
                        pend_vld_reg <= 1'b1;
                        pend_pat_reg <= p_reg;
                        pend_acc_reg <= !(own_reg || cell_own);
                        cnt_reg      <= cnt_reg + RC_W'(1);
                    end
                end
                S_CDRAIN: ;
                S_NEXT:
                    p_reg <= p_reg + PI_W'(1);
                S_DONE:
                begin
                    if (pend_vld_reg)
                    begin
                        result_strobe <= 1'b1;
                        match_pattern <= 4'(pend_pat_reg);
                        match_col     <= org_col_reg;
                        match_row     <= org_row_reg;
                        accepted      <= pend_acc_reg;
                        last          <= 1'b1;
                    end
                    pend_vld_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    // the final result of a probe is never directly followed by another
    a_last_ends_probe: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |=> !result_strobe)
        else $error("result after last of a probe");

    // no more results than the limit per probe
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RC_W'(RESULT_LIMIT))
        else $error("result count above limit");

    // claim memory changes only in the clear sweep or a claim pass
    a_claim_write: assert property (@(posedge clk) disable iff (!rst_n)
        claim_we |-> (state_reg == S_CLEAR || state_reg == S_CISSUE ||
                      state_reg == S_CDRAIN))
        else $error("claim write outside clear or claim pass");

    // a claim pass starts only from a match without owned cells
    a_claim_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MCHK && !cell_bad && (own_reg || cell_own) |=>
            state_reg != S_CISSUE)
        else $error("claim pass on a rejected match");
`endif

endmodule

`default_nettype wire
